### rtl/mbcsl_pkg.sv
// Shared types, constants and the character length decoder of the
// multibyte substring locator. No dependencies.
package mbcsl_pkg;

   localparam int unsigned MAX_BYTES  = 65535;
   localparam int unsigned BYTE_LIMIT = (MAX_BYTES > 65535) ? 65535 : MAX_BYTES;
   localparam int unsigned TAIL_CHARS = 64;            // power of two
   localparam int unsigned TAIL_W     = $clog2(TAIL_CHARS);
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] ASCII_TOP  = 8'h80;
   localparam logic [7:0] MASK_E0    = 8'hE0;
   localparam logic [7:0] MASK_C0    = 8'hC0;
   localparam logic [7:0] MASK_F0    = 8'hF0;
   localparam logic [7:0] MASK_F8    = 8'hF8;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NEG_LEN = 2'd1;
   localparam logic [1:0] STATUS_RANGE   = 2'd2;
   localparam logic [1:0] STATUS_LONG    = 2'd3;

   localparam logic [1:0] REG_START = 2'd0;
   localparam logic [1:0] REG_SPAN  = 2'd1;
   localparam logic [1:0] REG_MODE  = 2'd2;

   typedef struct packed {
      logic signed [16:0] start_position;
      logic signed [16:0] span_length;
      logic               encoding_mode;
   } cfg_type;

   // One queue entry: character starts found among up to four buffered bytes
   typedef struct packed {
      logic [3:0]  mask;     // bit i: a character starts at base + i
      logic [15:0] base;
      logic        fin;      // string ends with this entry
      logic        ovf;      // string exceeded the byte limit
      logic [15:0] end_pos;  // byte count of the string, valid with fin
   } entry_type;

   // Length of the character at b[0] given n bytes present; 0 means wait for more
   function automatic logic [2:0] lead_char_bytes(input logic [3:0][7:0] b,
                                                  input logic [2:0] n,
                                                  input logic at_end, input logic mode);
      logic [2:0] need;
      logic [2:0] r;
      logic       done;
      begin
         need = 3'd0;
         r    = 3'd1;
         done = 1'b0;
         if (b[0] < ASCII_TOP) begin
            r = 3'd1;
         end else if (mode) begin
            if (n >= 3'd2) r = 3'd2;
            else           r = at_end ? 3'd1 : 3'd0;
         end else begin
            if ((b[0] & MASK_E0) == MASK_C0)      need = 3'd2;
            else if ((b[0] & MASK_F0) == MASK_E0) need = 3'd3;
            else if ((b[0] & MASK_F8) == MASK_F0) need = 3'd4;
            if (need != 3'd0) begin
               r = need;
               for (int i = 1; i < 4; i++) begin
                  if (!done && (3'(i) < need)) begin
                     if (3'(i) >= n) begin
                        r = at_end ? 3'd1 : 3'd0;
                        done = 1'b1;
                     end else if ((b[i] & MASK_C0) != ASCII_TOP) begin
                        r = 3'd1;
                        done = 1'b1;
                     end
                  end
               end
            end
         end
         return r;
      end
   endfunction

endpackage

### rtl/multibyte_char_substring_locator.sv
// Multibyte (UTF-8 / MS949) character substring locator, top level.
// Throughput: one byte per cycle while the queue is not full; the back end takes the characters
// a byte completes one at a time (up to 4, single ring write port), then passes each string end
// through S_FIN1 and S_FIN2; the queue absorbs. A result passes through the queue, the S_CHAR,
// S_FIN1 and S_FIN2 states and the output register. Reset: synchronous, active high;
// clears control state; the ring needs no clearing. Depends on mbcsl_pkg and submodules.
module multibyte_char_substring_locator import mbcsl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,    // last_byte
   input  logic        req_tuser,    // empty_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // [1:0] status, [17:2] start_offset, [33:18] byte_count
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   entry_type f_entry, q_head;
   logic      f_push, q_full, q_empty, b_pop, b_upd, accept;
   logic [3:0]  b_mask;
   logic [1:0]  o_status;
   logic [15:0] o_start, o_count;

   // configuration registers: write only, one index per register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_START: cfg_in.start_position = csr_wdata;
            REG_SPAN:  cfg_in.span_length    = csr_wdata;
            REG_MODE:  cfg_in.encoding_mode  = csr_wdata[0];
            default:   cfg_in = cfg_ff;   // drop writes beyond the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_position <= 17'sd1;
         cfg_ff.span_length    <= 17'sd0;
         cfg_ff.encoding_mode  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // hold input transactions only while the queue is full
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   mbcsl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_tdata),
      .last_byte    (req_tlast),
      .empty_string (req_tuser),
      .mode         (cfg_ff.encoding_mode),
      .push         (f_push),
      .entry        (f_entry)
   );

   mbcsl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (f_push),
      .push_entry (f_entry),
      .full       (q_full),
      .pop        (b_pop),
      .upd        (b_upd),
      .upd_mask   (b_mask),
      .empty      (q_empty),
      .head       (q_head)
   );

   mbcsl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .empty      (q_empty),
      .head       (q_head),
      .pop        (b_pop),
      .upd        (b_upd),
      .upd_mask   (b_mask),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (o_status),
      .out_start  (o_start),
      .out_count  (o_count)
   );

   // pack result fields from the lowest bit up, pad to whole bytes
   assign rsp_tdata = {6'd0, o_count, o_start, o_status};

endmodule

### rtl/mbcsl_front.sv
// Front end: accepts bytes, keeps undecided bytes, marks character starts.
// Depends on mbcsl_pkg.
module mbcsl_front import mbcsl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  data_byte,
   input  logic        last_byte,
   input  logic        empty_string,
   input  logic        mode,
   output logic        push,
   output entry_type   entry
);

   logic [2:0][7:0] pend_ff, pend_in;
   logic [1:0]      pcnt_ff, pcnt_in;
   logic [15:0]     bpos_ff, bpos_in;
   logic            ovf_ff, ovf_in;

   logic            incl, at_end;
   logic [3:0][7:0] buff, sh, rest;
   logic [2:0]      n, p, stop_pos, len, lcnt;
   logic            stop;
   logic [3:0]      mask;

   always_comb begin
      incl   = !empty_string && ({16'd0, bpos_ff} < 32'(BYTE_LIMIT));
      at_end = last_byte || empty_string;
      buff   = {8'h00, pend_ff};
      if (incl) buff[pcnt_ff] = data_byte;
      n = {1'b0, pcnt_ff} + {2'b00, incl};

      p        = 3'd0;
      stop     = 1'b0;
      stop_pos = n;
      mask     = 4'd0;
      for (int i = 0; i < 4; i++) begin
         sh  = buff >> (8 * i);
         len = lead_char_bytes(sh, 3'(n - 3'(i)), at_end, mode);
         if (!stop && (p == 3'(i)) && (3'(i) < n)) begin
            if (len == 3'd0) begin
               stop     = 1'b1;
               stop_pos = 3'(i);
            end else begin
               mask[i] = 1'b1;
               p       = 3'(3'(i) + len);
            end
         end
      end
      rest = buff >> (8 * stop_pos);
      lcnt = n - stop_pos;

      entry.mask    = mask;
      entry.base    = bpos_ff - {14'd0, pcnt_ff};
      entry.fin     = at_end;
      entry.ovf     = ovf_ff || (!empty_string && !incl);
      entry.end_pos = bpos_ff + {15'd0, incl};
      push = accept && ((mask != 4'd0) || at_end);

      // drop all string state once the string ends
      if (at_end) begin
         pend_in = '0;
         pcnt_in = 2'd0;
         bpos_in = 16'd0;
         ovf_in  = 1'b0;
      end else begin
         pend_in = rest[2:0];
         pcnt_in = lcnt[1:0];
         bpos_in = entry.end_pos;
         ovf_in  = entry.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         pcnt_ff <= 2'd0;
         bpos_ff <= 16'd0;
         ovf_ff  <= 1'b0;
      end else if (accept) begin
         pend_ff <= pend_in;
         pcnt_ff <= pcnt_in;
         bpos_ff <= bpos_in;
         ovf_ff  <= ovf_in;
      end
   end

endmodule

### rtl/mbcsl_queue.sv
// Short entry queue between front and back; the head mask can be rewritten.
// Depends on mbcsl_pkg.
module mbcsl_queue import mbcsl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  entry_type   push_entry,
   output logic        full,
   input  logic        pop,
   input  logic        upd,
   input  logic [3:0]  upd_mask,
   output logic        empty,
   output entry_type   head
);

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   rd_ff, rd_in, wr_ff, wr_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;

   always_comb begin
      empty = (cnt_ff == '0);
      full  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      head  = slot_ff[rd_ff];
      rd_in = pop  ? rd_ff + 1'b1 : rd_ff;
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd) slot_ff[rd_ff].mask <= upd_mask;
      if (push) slot_ff[wr_ff] <= push_entry;
   end

endmodule

### rtl/mbcsl_back.sv
// Back end: counts characters, matches positions, keeps the offset ring
// and forms the result. Depends on mbcsl_pkg.
module mbcsl_back import mbcsl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        empty,
   input  entry_type   head,
   output logic        pop,
   output logic        upd,
   output logic [3:0]  upd_mask,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [1:0]  out_status,
   output logic [15:0] out_start,
   output logic [15:0] out_count
);

   localparam logic [1:0] S_CHAR = 2'd0;
   localparam logic [1:0] S_FIN1 = 2'd1;
   localparam logic [1:0] S_FIN2 = 2'd2;

   logic [15:0] ring [TAIL_CHARS];

   logic [1:0]        state_ff, state_in;
   logic [15:0]       cc_ff, cc_in;
   logic              sseen_ff, sseen_in, eseen_ff, eseen_in;
   logic [15:0]       fstart_ff, fstart_in, fend_ff, fend_in;
   logic [TAIL_W-1:0] tp_ff, tp_in;
   logic [15:0]       epos_ff, epos_in;
   logic              eovf_ff, eovf_in;
   logic [15:0]       rda_ff, rdb_ff;
   logic              ov_ff, ov_in;
   logic [1:0]        ost_ff, ost_in;
   logic [15:0]       ostart_ff, ostart_in, ocnt_ff, ocnt_in;

   logic [1:0]        idx;
   logic [3:0]        rem;
   logic              wr_en;
   logic [15:0]       offset;
   logic [16:0]       first_c;
   logic [17:0]       first_len, d18, len18;
   logic [TAIL_W-1:0] ra, rb;
   logic              far, load, out_free;
   logic [1:0]        st;
   logic [15:0]       first_v, last_v;

   always_comb begin
      idx = 2'd0;
      for (int i = 3; i >= 0; i--) if (head.mask[i]) idx = 2'(i);
      rem    = head.mask & ~(4'd1 << idx);
      offset = head.base + {14'd0, idx};

      first_c   = (cfg.start_position > 0) ? 17'(cfg.start_position - 17'sd1) : 17'd0;
      first_len = {1'b0, first_c} + {1'b0, cfg.span_length};
      d18       = 18'd0 - {cfg.start_position[16], cfg.start_position};
      len18     = {1'b0, cfg.span_length};
      ra        = tp_ff - d18[TAIL_W-1:0];
      rb        = tp_ff - d18[TAIL_W-1:0] + len18[TAIL_W-1:0];
      far       = (d18 > {2'b00, cc_ff}) || (d18 > 18'(TAIL_CHARS));

      // result from stable string state and the ring reads
      if (cfg.span_length[16])          st = STATUS_NEG_LEN;
      else if (eovf_ff)                 st = STATUS_LONG;
      else if (cfg.start_position[16])  st = far ? STATUS_RANGE : STATUS_OK;
      else                              st = sseen_ff ? STATUS_OK : STATUS_RANGE;
      if (cfg.start_position[16]) begin
         first_v = rda_ff;
         if (cfg.span_length == '0) last_v = rda_ff;
         else if (len18 < d18)     last_v = rdb_ff;
         else                      last_v = epos_ff;
      end else begin
         first_v = fstart_ff;
         if (cfg.span_length == '0) last_v = fstart_ff;
         else                      last_v = eseen_ff ? fend_ff : epos_ff;
      end

      out_free = !ov_ff || out_ready;
      state_in = state_ff;
      cc_in = cc_ff;  sseen_in = sseen_ff;  eseen_in = eseen_ff;
      fstart_in = fstart_ff;  fend_in = fend_ff;  tp_in = tp_ff;
      epos_in = epos_ff;  eovf_in = eovf_ff;
      pop = 1'b0;  upd = 1'b0;  upd_mask = rem;  wr_en = 1'b0;  load = 1'b0;

      unique case (state_ff)
         S_CHAR: begin
            if (!empty) begin
               if (head.mask != 4'd0) begin
                  wr_en = 1'b1;
                  tp_in = (tp_ff == TAIL_W'(TAIL_CHARS - 1)) ? '0 : tp_ff + 1'b1;
                  if (!cfg.start_position[16]) begin
                     if (({1'b0, cc_ff} == first_c) && !sseen_ff) begin
                        fstart_in = offset;
                        sseen_in  = 1'b1;
                     end
                     if ((cfg.span_length > 0) && ({2'b00, cc_ff} == first_len) &&
                         !eseen_ff) begin
                        fend_in  = offset;
                        eseen_in = 1'b1;
                     end
                  end
                  cc_in = cc_ff + 16'd1;
               end
               if ((head.mask == 4'd0) || (rem == 4'd0)) begin
                  pop = 1'b1;
                  if (head.fin) begin
                     epos_in  = head.end_pos;
                     eovf_in  = head.ovf;
                     state_in = S_FIN1;
                  end
               end else begin
                  upd = 1'b1;
               end
            end
         end
         S_FIN1: state_in = S_FIN2;
         S_FIN2: begin
            if (out_free) begin
               load = 1'b1;
               cc_in = '0;  sseen_in = 1'b0;  eseen_in = 1'b0;
               fstart_in = '0;  fend_in = '0;  tp_in = '0;
               state_in = S_CHAR;
            end
         end
         default: state_in = S_CHAR;
      endcase

      ov_in = load ? 1'b1 : (out_ready ? 1'b0 : ov_ff);
      ost_in = st;
      if ((st != STATUS_OK) || (last_v < first_v)) begin
         ostart_in = '0;
         ocnt_in   = '0;
      end else begin
         ostart_in = first_v;
         ocnt_in   = last_v - first_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CHAR;
         cc_ff <= '0;  sseen_ff <= 1'b0;  eseen_ff <= 1'b0;
         fstart_ff <= '0;  fend_ff <= '0;  tp_ff <= '0;
         epos_ff <= '0;  eovf_ff <= 1'b0;  ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cc_ff <= cc_in;  sseen_ff <= sseen_in;  eseen_ff <= eseen_in;
         fstart_ff <= fstart_in;  fend_ff <= fend_in;  tp_ff <= tp_in;
         epos_ff <= epos_in;  eovf_ff <= eovf_in;  ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) ring[tp_ff] <= offset;
      rda_ff <= ring[ra];
      rdb_ff <= ring[rb];
      if (load) begin
         ost_ff    <= ost_in;
         ostart_ff <= ostart_in;
         ocnt_ff   <= ocnt_in;
      end
   end

   assign out_valid  = ov_ff;
   assign out_status = ost_ff;
   assign out_start  = ostart_ff;
   assign out_count  = ocnt_ff;

endmodule

### verif/tb_multibyte_char_substring_locator.sv
// Self-checking testbench of the multibyte substring locator: directed table, random strings
// under random register settings and back-pressure, checked against a behavioural predictor.
// Depends on mbcsl_pkg and the multibyte_char_substring_locator RTL.
`timescale 1ns / 1ps

module tb_multibyte_char_substring_locator import mbcsl_pkg::*; ();

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic        req_tlast;    // last_byte
   logic        req_tuser;    // empty_string
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // [1:0] status, [17:2] start_offset, [33:18] byte_count
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [16:0] csr_wdata;

   multibyte_char_substring_locator DUT (.*);

   typedef struct {
      logic [1:0]  status;
      logic [15:0] offset;
      logic [15:0] count;
   } span_type;

   // One row of the directed table; cfg rows rewrite all registers first
   typedef struct {
      bit          cfg;
      int          start;
      int          span;
      bit          mode;
      logic [7:0]  data;
      bit          last;
      bit          empty;
      bit          fixed;
      logic [1:0]  status;
      logic [15:0] offset;
      logic [15:0] count;
   } dir_row_type;

   span_type    span_q[$];       // substring spans still owed by the block
   logic [7:0]  text_q[$];       // bytes of the string being built
   int          errors = 0;
   int          spans_seen = 0;
   int          items_sent = 0;
   int          strings_sent = 0;
   int          settings_used = 0;
   bit          calm = 0;        // no idling in the closing part
   bit          hold_req = 0;    // sender asks for the long receiver hold
   bit          long_hold_done = 0;

   // Predictor registers and string state
   logic signed [16:0] p_start;
   logic signed [16:0] p_span;
   logic               p_mode;
   int          p_pos, p_chars, p_pend_n, p_start_off, p_end_off, p_tail;
   logic [7:0]  p_pend [3];
   bit          p_start_seen, p_end_seen, p_ovf;
   logic [15:0] p_ring [TAIL_CHARS];

   dir_row_type dir_tab [] = '{
      // after reset: start 1, span 0, UTF-8
      '{0, 0, 0, 0, 8'h41, 1, 0, 1, STATUS_OK, 16'd0, 16'd0},
      '{0, 0, 0, 0, 8'h00, 0, 1, 1, STATUS_RANGE, 16'd0, 16'd0},
      '{0, 0, 0, 0, 8'h00, 1, 0, 1, STATUS_OK, 16'd0, 16'd0},
      // two, three and four byte characters, then a span
      '{1, 1, 2, 0, 8'hC3, 0, 0, 0, STATUS_OK, 0, 0},
      '{0, 0, 0, 0, 8'hA9, 0, 0, 0, STATUS_OK, 0, 0},
      '{0, 0, 0, 0, 8'hE2, 0, 0, 0, STATUS_OK, 0, 0},
      '{0, 0, 0, 0, 8'h82, 0, 0, 0, STATUS_OK, 0, 0},
      '{0, 0, 0, 0, 8'hAC, 0, 0, 0, STATUS_OK, 0, 0},
      '{0, 0, 0, 0, 8'hF0, 0, 0, 0, STATUS_OK, 0, 0},
      '{0, 0, 0, 0, 8'h9F, 0, 0, 0, STATUS_OK, 0, 0},
      '{0, 0, 0, 0, 8'h98, 0, 0, 0, STATUS_OK, 0, 0},
      '{0, 0, 0, 0, 8'h80, 1, 0, 0, STATUS_OK, 0, 0},
      // lead byte cut off by the string end, broken continuations
      '{0, 0, 0, 0, 8'hF0, 1, 0, 0, STATUS_OK, 0, 0},
      '{0, 0, 0, 0, 8'hFF, 0, 0, 0, STATUS_OK, 0, 0},
      '{0, 0, 0, 0, 8'h80, 0, 0, 0, STATUS_OK, 0, 0},
      '{0, 0, 0, 0, 8'hC3, 0, 0, 0, STATUS_OK, 0, 0},
      '{0, 0, 0, 0, 8'h41, 0, 1, 0, STATUS_OK, 0, 0},
      // negative length, far negative start, start past the end
      '{1, 1, -1, 0, 8'h41, 1, 0, 1, STATUS_NEG_LEN, 16'd0, 16'd0},
      '{1, -64, 65535, 0, 8'h41, 1, 0, 1, STATUS_RANGE, 16'd0, 16'd0},
      '{1, 65535, 0, 0, 8'h41, 1, 0, 1, STATUS_RANGE, 16'd0, 16'd0},
      // MS949 with a lead byte on the last position
      '{1, -1, 1, 1, 8'hB0, 0, 0, 0, STATUS_OK, 0, 0},
      '{0, 0, 0, 0, 8'hA1, 0, 0, 0, STATUS_OK, 0, 0},
      '{0, 0, 0, 0, 8'h41, 0, 0, 0, STATUS_OK, 0, 0},
      '{0, 0, 0, 0, 8'hB0, 1, 0, 0, STATUS_OK, 0, 0},
      '{1, 0, 1, 0, 8'h7F, 1, 0, 0, STATUS_OK, 0, 0}
   };

   // ---------------------------------------------------------------- predictor

   function automatic int char_bytes(logic [7:0] win [4], int n, bit at_end);
      int need;
      if (win[0] < ASCII_TOP) return 1;
      if (p_mode) return (n >= 2) ? 2 : (at_end ? 1 : 0);
      if ((win[0] & MASK_E0) == MASK_C0)      need = 2;
      else if ((win[0] & MASK_F0) == MASK_E0) need = 3;
      else if ((win[0] & MASK_F8) == MASK_F0) need = 4;
      else return 1;
      for (int i = 1; i < need; i++) begin
         if (i >= n) return at_end ? 1 : 0;
         if ((win[i] & MASK_C0) != ASCII_TOP) return 1;
      end
      return need;
   endfunction

   task automatic note_char(int offset);
      int s;
      int len;
      int first;
      s   = p_start;
      len = p_span;
      p_ring[p_tail] = offset[15:0];
      p_tail = (p_tail + 1) % TAIL_CHARS;
      if (s >= 0) begin
         first = (s > 0) ? s - 1 : 0;
         if (p_chars == first && !p_start_seen) begin
            p_start_off  = offset;
            p_start_seen = 1;
         end
         if (len > 0 && p_chars == first + len && !p_end_seen) begin
            p_end_off  = offset;
            p_end_seen = 1;
         end
      end
      p_chars = (p_chars + 1) & 16'hFFFF;
   endtask

   task automatic split_chars(logic [7:0] win [4], int n, int base, bit at_end);
      int at;
      int len;
      logic [7:0] rest [4];
      at = 0;
      while (at < n) begin
         for (int i = 0; i < 4; i++) rest[i] = (at + i < 4) ? win[at + i] : 8'h00;
         len = char_bytes(rest, n - at, at_end);
         if (len == 0) break;
         note_char(base + at);
         at += len;
      end
      p_pend_n = 0;
      for (int i = 0; at + i < n && i < 3; i++) begin
         p_pend[i] = win[at + i];
         p_pend_n  = i + 1;
      end
   endtask

   function automatic int ring_back(int d);
      return p_ring[(p_tail + TAIL_CHARS - d) % TAIL_CHARS];
   endfunction

   task automatic clear_string();
      p_pos = 0; p_chars = 0; p_pend_n = 0; p_tail = 0;
      p_start_off = 0; p_end_off = 0;
      p_start_seen = 0; p_end_seen = 0; p_ovf = 0;
      for (int i = 0; i < 3; i++) p_pend[i] = 8'h00;
   endtask

   task automatic close_string(output span_type r);
      logic [7:0] win [4];
      int s, len, d, e, first, last;
      logic [1:0] st;
      for (int i = 0; i < 4; i++) win[i] = (i < 3) ? p_pend[i] : 8'h00;
      split_chars(win, p_pend_n, p_pos - p_pend_n, 1);
      s = p_start; len = p_span; first = 0; last = 0; st = STATUS_OK;
      if (len < 0) st = STATUS_NEG_LEN;
      else if (p_ovf) st = STATUS_LONG;
      else if (s < 0) begin
         d = -s;
         if (d > p_chars || d > TAIL_CHARS) st = STATUS_RANGE;
         else begin
            first = ring_back(d);
            if (len == 0) last = first;
            else begin
               e = p_chars - d + len;
               last = (e < p_chars) ? ring_back(p_chars - e) : p_pos;
            end
         end
      end else if (!p_start_seen) st = STATUS_RANGE;
      else begin
         first = p_start_off;
         last  = (len == 0) ? first : (p_end_seen ? p_end_off : p_pos);
      end
      if (st != STATUS_OK || last < first) begin
         first = 0;
         last  = 0;
      end
      r.status = st;
      r.offset = first[15:0];
      r.count  = 16'((last - first) & 16'hFFFF);
      clear_string();
   endtask

   // Advance the predictor by one accepted transaction; done flags a span
   task automatic locate_step(logic [7:0] data, bit last, bit empty,
                              output bit done, output span_type r);
      logic [7:0] win [4];
      done = 0;
      if (empty) begin
         close_string(r);
         done = 1;
         return;
      end
      if (p_pos >= BYTE_LIMIT) p_ovf = 1;
      else begin
         for (int i = 0; i < 4; i++) win[i] = (i < p_pend_n) ? p_pend[i] : 8'h00;
         win[p_pend_n] = data;
         p_pos++;
         split_chars(win, p_pend_n + 1, p_pos - (p_pend_n + 1), 0);
      end
      if (last) begin
         close_string(r);
         done = 1;
      end
   endtask

   // ---------------------------------------------------------------- clock, reset, limit

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("%0t: timeout, %0d spans still owed", $time, span_q.size());
      $display("** multibyte_char_substring_locator: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   // Stall in random bursts; once, hold off for a long stretch so the block backs up
   initial begin
      rsp_tready = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && hold_req) begin
            long_hold_done = 1;
            rsp_tready <= 0;
            repeat (600) @(posedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   // Compare each span transaction with the oldest one owed
   always @(posedge clock) begin
      span_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         spans_seen++;
         if (span_q.size() == 0) begin
            $display("%0t: unexpected span transaction, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = span_q.pop_front();
            if (rsp_tdata[1:0] !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_tdata[1:0]);
               errors++;
            end
            if (rsp_tdata[17:2] !== want.offset) begin
               $display("%0t: start_offset expected %0d actual %0d",
                        $time, want.offset, rsp_tdata[17:2]);
               errors++;
            end
            if (rsp_tdata[33:18] !== want.count) begin
               $display("%0t: byte_count expected %0d actual %0d",
                        $time, want.count, rsp_tdata[33:18]);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- sender

   // Offer one byte transaction, idling first at random; record the span it closes
   task automatic send_byte(logic [7:0] data, bit last, bit empty,
                            bit fixed = 0, span_type typed = '{0, 0, 0});
      bit       done;
      span_type r;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= data;
      req_tlast  <= last;
      req_tuser  <= empty;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      locate_step(data, last, empty, done, r);
      if (done) begin
         span_q.push_back(fixed ? typed : r);
         strings_sent++;
      end
   endtask

   // Drain the block, let its pipeline settle, then rewrite every register
   task automatic set_registers(int start, int span, bit mode);
      req_tvalid <= 0;
      while (span_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_we    <= 1;
      csr_index <= REG_START;
      csr_wdata <= start[16:0];
      @(posedge clock);
      csr_index <= REG_SPAN;
      csr_wdata <= span[16:0];
      @(posedge clock);
      csr_index <= REG_MODE;
      csr_wdata <= {16'd0, mode};
      @(posedge clock);
      csr_we <= 0;
      p_start = start[16:0];
      p_span  = span[16:0];
      p_mode  = mode;
      settings_used++;
   endtask

   // Build one string: mostly well-formed characters, some raw noise
   task automatic build_string(int chars);
      int kind;
      text_q.delete();
      for (int c = 0; c < chars; c++) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) text_q.push_back(8'($urandom));
         else if (kind < 4) text_q.push_back(8'($urandom_range(0, 127)));
         else if (p_mode) begin
            text_q.push_back(8'($urandom_range(128, 255)));
            text_q.push_back(8'($urandom));
         end else begin
            kind = $urandom_range(2, 4);
            if (kind == 2) text_q.push_back({3'b110, 5'($urandom)});
            else if (kind == 3) text_q.push_back({4'b1110, 4'($urandom)});
            else text_q.push_back({5'b11110, 3'($urandom)});
            for (int k = 1; k < kind; k++)
               text_q.push_back($urandom_range(0, 11) == 0 ? 8'($urandom)
                                                           : {2'b10, 6'($urandom)});
         end
      end
   endtask

   function automatic int pick_start();
      case ($urandom_range(0, 6))
         0: return 0;
         1: return $urandom_range(1, 8);
         2: return -$urandom_range(1, 8);
         3: return -$urandom_range(9, 70);
         4: return $urandom_range(0, 1) ? 65535 : -64;
         default: return $urandom_range(1, 40);
      endcase
   endfunction

   function automatic int pick_span();
      case ($urandom_range(0, 5))
         0: return -1;
         1: return 0;
         2: return 65535;
         3: return $urandom_range(1, 4);
         default: return $urandom_range(1, 40);
      endcase
   endfunction

   initial begin
      span_type typed;
      int       ending;
      reset      = 1;
      req_tvalid = 0;
      req_tdata  = 0;
      req_tlast  = 0;
      req_tuser  = 0;
      csr_we     = 0;
      csr_index  = REG_START;
      csr_wdata  = 0;
      p_start = 17'sd1;
      p_span  = 17'sd0;
      p_mode  = 0;
      clear_string();
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed rows; typed spans stand where they are plain to see
      foreach (dir_tab[i]) begin
         if (dir_tab[i].cfg) set_registers(dir_tab[i].start, dir_tab[i].span, dir_tab[i].mode);
         typed = '{dir_tab[i].status, dir_tab[i].offset, dir_tab[i].count};
         send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].empty, dir_tab[i].fixed, typed);
      end

      // Random phases: new settings, then a handful of strings; sender keeps
      // offering while the receiver holds off
      while (items_sent < 1100) begin
         set_registers(pick_start(), pick_span(), 1'($urandom));
         if (!long_hold_done && items_sent >= 200) hold_req = 1;
         repeat ($urandom_range(4, 14)) begin
            if (items_sent >= 1100) break;
            if (items_sent > 900) calm = 1;
            ending = $urandom_range(0, 19);
            if (ending == 0) send_byte(8'($urandom), 1'($urandom), 1);
            else begin
               build_string($urandom_range(1, 24));
               foreach (text_q[k])
                  send_byte(text_q[k], (ending > 2) && (k == text_q.size() - 1), 0);
               if (ending <= 2) send_byte(8'($urandom), 1'($urandom), 1);
            end
         end
      end

      req_tvalid <= 0;
      while (span_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d transactions in %0d strings (%0d spans checked) over %0d settings,",
               items_sent, strings_sent, spans_seen, settings_used);
      $display("including UTF-8 and MS949 text, empty strings and a long output stall.");
      if (errors == 0) begin
         $display("** multibyte_char_substring_locator: PASSED **");
      end else begin
         $display("** multibyte_char_substring_locator: FAILED **");
      end
      $finish;
   end

endmodule
